### design/window_max_pool_with_argmax_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the window max pool unit
// Concurrent property shorthands sampled on clk_i, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef WINDOW_MAX_POOL_WITH_ARGMAX_UNIT_ASSERT_SVH
`define WINDOW_MAX_POOL_WITH_ARGMAX_UNIT_ASSERT_SVH

// same-cycle implication
`define WMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window max pool check failed");

// next-cycle implication
`define WMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window max pool check failed");

`endif

### design/wmp_pkg.sv
// ---------------------------------------------------------------------------
// Window max pool package
// Widths, register indices, reset values, sequencer states and config record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmp_pkg;

  localparam int STORE_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_WINDOW_DEF  = 8;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIM_BITS       = 11;
  localparam int PLANE_CNT_BITS = 13;
  localparam int WIN_BITS       = 4;
  localparam int STEP_BITS      = 4;
  localparam int PAD_BITS       = 3;
  localparam int POS_BITS       = 10;
  localparam int PLANE_BITS     = 12;
  localparam int ADDR_BITS      = 16;
  localparam int INDEX_BITS     = 17;
  localparam int COORD_BITS     = 17;
  localparam int OFFS_BITS      = POS_BITS + STEP_BITS;
  localparam int PBASE_BITS     = PLANE_BITS + DIM_BITS;
  localparam int CHB_BITS       = PBASE_BITS + 2;
  localparam int BASE_BITS      = 40;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IN_WIDTH    = 3'd0,
    CFG_IN_HEIGHT   = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_PLANE_COUNT = 3'd4,
    CFG_WINDOW_SIZE = 3'd5,
    CFG_STEP        = 3'd6,
    CFG_PADDING     = 3'd7
  } wmp_cfg_idx_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_POOL  = 1'b1
  } wmp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } wmp_state_e;

  typedef struct packed {
    logic [DIM_BITS-1:0]       in_width;
    logic [DIM_BITS-1:0]       in_height;
    logic [DIM_BITS-1:0]       out_width;
    logic [DIM_BITS-1:0]       out_height;
    logic [PLANE_CNT_BITS-1:0] plane_count;
    logic [WIN_BITS-1:0]       window_size;
    logic [STEP_BITS-1:0]      step;
    logic [PAD_BITS-1:0]       padding;
  } wmp_cfg_t;

  localparam wmp_cfg_t CFG_RESET = '{
    in_width:    11'd1,
    in_height:   11'd1,
    out_width:   11'd1,
    out_height:  11'd1,
    plane_count: 13'd1,
    window_size: 4'd2,
    step:        4'd2,
    padding:     3'd0
  };

endpackage

`default_nettype wire

### design/wmp_store.sv
// ---------------------------------------------------------------------------
// Window max pool feature store
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmp_store
  import wmp_pkg::*;
#(
  parameter int DEPTH     = STORE_DEPTH_DEF,
  parameter int DATA_BITS = SAMPLE_BITS_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/window_max_pool_with_argmax_unit.sv
// ---------------------------------------------------------------------------
// Window max pool with argmax
// Sample store plus a window scanner returning the maximum and its index.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  in      | in_valid_i/in_ready_o  | operation_i, address_i, sample_i,
//          |                        | out_col_i, out_row_i, plane_i
//  out     | out_valid_o/out_ready_i| max_value_o, max_index_o, found_o
//
//  A store transaction leaves the unit idle; the next one is taken straight after.
//  A pool transaction goes through setup, row, scan, drain and done; the scan
//  visits W*W positions, W the window side capped at MAX_WINDOW, one a cycle.
//  Out-of-range requests and a zero window size go from setup straight to done.
//  Reset restores the configuration, sequencer and output-valid registers; store contents are undefined until written.
//  The result waits in the output register; a later pool holds until it goes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_max_pool_with_argmax_unit
  import wmp_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [ADDR_BITS-1:0]          address_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [POS_BITS-1:0]           out_col_i,
  input  wire logic [POS_BITS-1:0]           out_row_i,
  input  wire logic [PLANE_BITS-1:0]         plane_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      max_value_o,
  output logic signed [INDEX_BITS-1:0]       max_index_o,
  output logic                               found_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam logic [SAMPLE_BITS-1:0] SENTINEL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  wmp_cfg_t   cfg_q;
  wmp_state_e state_q, state_d;

  logic [POS_BITS-1:0]   col_q, row_q;
  logic [PLANE_BITS-1:0] pl_q;

  logic signed [COORD_BITS-1:0] h0_q, w0_q, h0_d, w0_d;
  logic [PBASE_BITS-1:0]        pbase_q, pbase_d;
  logic [WW-1:0]                win_q, win_d;
  logic [OFFS_BITS-1:0]         row_off, col_off;
  logic                         in_range;

  logic signed [CHB_BITS-1:0]   ch_base;
  logic signed [BASE_BITS-1:0]  row_base_q, row_base_d;
  logic [WW-1:0]                r_q, c_q;

  logic signed [COORD_BITS-1:0] ch, cw;
  logic signed [BASE_BITS-1:0]  pos_idx;
  logic                         ch_ok, cw_ok, idx_ok, last_col, last_pos;

  logic                         rd_en, rd_vld_q;
  logic [INDEX_BITS-1:0]        rd_idx_q;
  logic [SAMPLE_BITS-1:0]       rdata;

  logic signed [SAMPLE_BITS-1:0] best_q;
  logic [INDEX_BITS-1:0]         best_idx_q;
  logic                          best_found_q;

  logic                          out_valid_q, out_found_q;
  logic [SAMPLE_BITS-1:0]        out_value_q;
  logic [INDEX_BITS-1:0]         out_index_q;

  logic in_acc, pool_acc, store_we, scan_active, load_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (wmp_cfg_idx_e'(cfg_index_i))
        CFG_IN_WIDTH:    cfg_q.in_width    <= cfg_data_i[DIM_BITS-1:0];
        CFG_IN_HEIGHT:   cfg_q.in_height   <= cfg_data_i[DIM_BITS-1:0];
        CFG_OUT_WIDTH:   cfg_q.out_width   <= cfg_data_i[DIM_BITS-1:0];
        CFG_OUT_HEIGHT:  cfg_q.out_height  <= cfg_data_i[DIM_BITS-1:0];
        CFG_PLANE_COUNT: cfg_q.plane_count <= cfg_data_i[PLANE_CNT_BITS-1:0];
        CFG_WINDOW_SIZE: cfg_q.window_size <= cfg_data_i[WIN_BITS-1:0];
        CFG_STEP:        cfg_q.step        <= cfg_data_i[STEP_BITS-1:0];
        CFG_PADDING:     cfg_q.padding     <= cfg_data_i[PAD_BITS-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // window setup
  assign row_off  = row_q * cfg_q.step;
  assign col_off  = col_q * cfg_q.step;
  assign h0_d     = COORD_BITS'(row_off) - COORD_BITS'(cfg_q.padding);
  assign w0_d     = COORD_BITS'(col_off) - COORD_BITS'(cfg_q.padding);
  assign pbase_d  = pl_q * cfg_q.in_height;
  assign in_range = (DIM_BITS'(col_q) < cfg_q.out_width) &&
                    (DIM_BITS'(row_q) < cfg_q.out_height) &&
                    (PLANE_CNT_BITS'(pl_q) < cfg_q.plane_count);
  assign win_d    = (32'(cfg_q.window_size) > MAX_WINDOW) ? WW'(MAX_WINDOW)
                                                          : WW'(cfg_q.window_size);

  assign ch_base    = CHB_BITS'(h0_q) + $signed(CHB_BITS'(pbase_q));
  assign row_base_d = ch_base * $signed({1'b0, cfg_q.in_width});

  // scan position
  assign ch      = h0_q + $signed(COORD_BITS'(r_q));
  assign cw      = w0_q + $signed(COORD_BITS'(c_q));
  assign ch_ok   = (ch >= 0) && (ch < $signed(COORD_BITS'(cfg_q.in_height)));
  assign cw_ok   = (cw >= 0) && (cw < $signed(COORD_BITS'(cfg_q.in_width)));
  assign pos_idx = row_base_q + BASE_BITS'(cw);
  assign idx_ok  = pos_idx < $signed(BASE_BITS'(STORE_DEPTH));

  assign last_col = (c_q == win_q - WW'(1));
  assign last_pos = last_col && (r_q == win_q - WW'(1));

  assign in_acc   = in_valid_i && in_ready_o;
  assign pool_acc = in_acc && (wmp_op_e'(operation_i) == OP_POOL);
  assign store_we = in_acc && (wmp_op_e'(operation_i) == OP_STORE) &&
                    (32'(address_i) < STORE_DEPTH);
  assign rd_en    = scan_active && ch_ok && cw_ok && idx_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pool_acc) state_d = ST_SETUP;
      ST_SETUP: state_d = (in_range && (win_d != '0)) ? ST_ROW : ST_DONE;
      ST_ROW:   state_d = ST_SCAN;
      ST_SCAN:  if (last_pos) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    scan_active = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_SCAN: scan_active = 1'b1;
      ST_DONE: load_out    = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pool_acc) begin
      col_q        <= out_col_i;
      row_q        <= out_row_i;
      pl_q         <= plane_i;
      best_q       <= SENTINEL;
      best_idx_q   <= '1;
      best_found_q <= 1'b0;
    end
    if (state_q == ST_SETUP) begin
      h0_q    <= h0_d;
      w0_q    <= w0_d;
      pbase_q <= pbase_d;
      win_q   <= win_d;
    end
    if (state_q == ST_ROW) begin
      row_base_q <= row_base_d;
      r_q        <= '0;
      c_q        <= '0;
    end
    if (scan_active) begin
      if (last_col) begin
        c_q        <= '0;
        r_q        <= r_q + WW'(1);
        row_base_q <= row_base_q + BASE_BITS'(cfg_q.in_width);
      end else begin
        c_q <= c_q + WW'(1);
      end
    end
    rd_idx_q <= pos_idx[INDEX_BITS-1:0];
    if (rd_vld_q && ($signed(rdata) > best_q)) begin
      best_q       <= $signed(rdata);
      best_idx_q   <= rd_idx_q;
      best_found_q <= 1'b1;
    end
    if (load_out) begin
      out_value_q <= best_q;
      out_index_q <= best_idx_q;
      out_found_q <= best_found_q;
    end
  end

  wmp_store #(
    .DEPTH     (STORE_DEPTH),
    .DATA_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (AW'(address_i)),
    .wdata_i (sample_i),
    .re_i    (rd_en),
    .raddr_i (pos_idx[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign max_value_o = out_value_q;
  assign max_index_o = out_index_q;
  assign found_o     = out_found_q;

endmodule

`default_nettype wire

### design/wmp_checker.sv
// ---------------------------------------------------------------------------
// Window max pool port checker
// Port-level properties of the pool unit, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "window_max_pool_with_argmax_unit_assert.svh"

module wmp_checker
  import wmp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   operation_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] max_value_o,
  input wire logic [INDEX_BITS-1:0]  max_index_o,
  input wire logic                   found_o
);

  localparam logic [SAMPLE_BITS-1:0] SENTINEL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  `WMP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  `WMP_ASSERT_SAME(a_empty_sentinel, out_valid_o && !found_o, (max_index_o == '1) && (max_value_o == SENTINEL))

  `WMP_ASSERT_SAME(a_found_beats, out_valid_o && found_o, max_value_o != SENTINEL)

  `WMP_ASSERT_NEXT(a_pool_busy, in_valid_i && in_ready_o && (operation_i == OP_POOL), !in_ready_o)

  `WMP_ASSERT_SAME(a_load_busy, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind window_max_pool_with_argmax_unit wmp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wmp_checker (.*);

`default_nettype wire

### dv/window_max_pool_with_argmax_unit_checker.sv
// ---------------------------------------------------------------------------
// Window max pool checker
// Watches the register, input and result channels, keeps its own copy of the
// sample store and register set, predicts every pool result and compares it
// field by field with what the unit returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_max_pool_with_argmax_unit_checker
  import wmp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [ADDR_BITS-1:0]     address_i,
  input  logic [SAMPLE_BITS_DEF-1:0] sample_i,
  input  logic [POS_BITS-1:0]      out_col_i,
  input  logic [POS_BITS-1:0]      out_row_i,
  input  logic [PLANE_BITS-1:0]    plane_i,
  input  logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic [SAMPLE_BITS_DEF-1:0] max_value_o,
  input  logic [INDEX_BITS-1:0]    max_index_o,
  input  logic                     found_o,
  output int                       err_count_o,
  output int                       pending_o
);

  localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] value;
    logic [INDEX_BITS-1:0]      index;
    logic                       found;
  } pool_result_t;

  logic [SAMPLE_BITS_DEF-1:0] sample_mem [STORE_DEPTH_DEF];
  wmp_cfg_t                   pool_cfg;
  pool_result_t               pooled_q [$];
  pool_result_t               oldest;
  int                         mismatches;

  function automatic pool_result_t predict_window_max(input logic [POS_BITS-1:0] col,
                                                      input logic [POS_BITS-1:0] row,
                                                      input logic [PLANE_BITS-1:0] pl);
    pool_result_t res;
    int           win;
    int           r;
    int           c;
    longint       h0;
    longint       w0;
    longint       ch;
    longint       cw;
    longint       flat;
    logic signed [SAMPLE_BITS_DEF-1:0] v;
    res.value = SAMPLE_MIN;
    res.index = '1;
    res.found = 1'b0;
    win = (pool_cfg.window_size > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(pool_cfg.window_size);
    if (col < pool_cfg.out_width && row < pool_cfg.out_height && pl < pool_cfg.plane_count) begin
      h0 = longint'(row) * longint'(pool_cfg.step) - longint'(pool_cfg.padding);
      w0 = longint'(col) * longint'(pool_cfg.step) - longint'(pool_cfg.padding);
      for (r = 0; r < win; r++) begin
        ch = h0 + r;
        if (ch >= 0 && ch < longint'(pool_cfg.in_height)) begin
          for (c = 0; c < win; c++) begin
            cw = w0 + c;
            if (cw >= 0 && cw < longint'(pool_cfg.in_width)) begin
              flat = cw + longint'(pool_cfg.in_width) *
                     (ch + longint'(pool_cfg.in_height) * longint'(pl));
              if (flat < STORE_DEPTH_DEF) begin
                v = sample_mem[int'(flat)];
                if (v > $signed(res.value)) begin
                  res.value = v;
                  res.index = flat[INDEX_BITS-1:0];
                  res.found = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_cfg = CFG_RESET;
      pooled_q.delete();
      mismatches = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (wmp_cfg_idx_e'(cfg_index_i))
          CFG_IN_WIDTH:    pool_cfg.in_width    = cfg_data_i[DIM_BITS-1:0];
          CFG_IN_HEIGHT:   pool_cfg.in_height   = cfg_data_i[DIM_BITS-1:0];
          CFG_OUT_WIDTH:   pool_cfg.out_width   = cfg_data_i[DIM_BITS-1:0];
          CFG_OUT_HEIGHT:  pool_cfg.out_height  = cfg_data_i[DIM_BITS-1:0];
          CFG_PLANE_COUNT: pool_cfg.plane_count = cfg_data_i[PLANE_CNT_BITS-1:0];
          CFG_WINDOW_SIZE: pool_cfg.window_size = cfg_data_i[WIN_BITS-1:0];
          CFG_STEP:        pool_cfg.step        = cfg_data_i[STEP_BITS-1:0];
          CFG_PADDING:     pool_cfg.padding     = cfg_data_i[PAD_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (pooled_q.size() == 0) begin
          flag_error("unexpected result, max_value", 0, $signed(max_value_o));
        end else begin
          oldest = pooled_q.pop_front();
          if (oldest.value !== max_value_o)
            flag_error("max_value", $signed(oldest.value), $signed(max_value_o));
          if (oldest.index !== max_index_o)
            flag_error("max_index", $signed(oldest.index), $signed(max_index_o));
          if (oldest.found !== found_o)
            flag_error("found", oldest.found, found_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (operation_i == OP_STORE) begin
          sample_mem[address_i] = sample_i;
        end else begin
          pooled_q.push_back(predict_window_max(out_col_i, out_row_i, plane_i));
        end
      end
      err_count_o <= mismatches;
      pending_o <= pooled_q.size();
    end
  end

endmodule

### dv/window_max_pool_with_argmax_unit_tb.sv
// ---------------------------------------------------------------------------
// Window max pool testbench
// Writes every store entry a window touches before pooling it, runs directed
// windows (ties, sentinel-only, padding, clipped and out-of-range requests,
// oversized maps) and then random phases of stores and pool queries under
// varied register settings, with random idling on the input and result
// channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_max_pool_with_argmax_unit_tb;
  import wmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 200;
  localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = 16'h7fff;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]           cfg_index_i;
  logic [CFG_DATA_BITS-1:0]          cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              operation_i;
  logic [ADDR_BITS-1:0]              address_i;
  logic signed [SAMPLE_BITS_DEF-1:0] sample_i;
  logic [POS_BITS-1:0]               out_col_i;
  logic [POS_BITS-1:0]               out_row_i;
  logic [PLANE_BITS-1:0]             plane_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [SAMPLE_BITS_DEF-1:0] max_value_o;
  logic signed [INDEX_BITS-1:0]      max_index_o;
  logic                              found_o;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit cfg_junk;
  int cur_iw, cur_ih, cur_ow, cur_oh, cur_pc;
  int cur_ws, cur_st, cur_pd;
  int n_store, n_pool, n_cfg;
  int quiet_cycles = 0;
  int stall_left;
  bit stored [STORE_DEPTH_DEF];

  window_max_pool_with_argmax_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .address_i   (address_i),
    .sample_i    (sample_i),
    .out_col_i   (out_col_i),
    .out_row_i   (out_row_i),
    .plane_i     (plane_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .max_value_o (max_value_o),
    .max_index_o (max_index_o),
    .found_o     (found_o)
  );

  window_max_pool_with_argmax_unit_checker u_pool_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .address_i   (address_i),
    .sample_i    (sample_i),
    .out_col_i   (out_col_i),
    .out_row_i   (out_row_i),
    .plane_i     (plane_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .max_value_o (max_value_o),
    .max_index_o (max_index_o),
    .found_o     (found_o),
    .err_count_o (mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      if ($urandom_range(9) == 0) return $urandom_range(60, 20);
      return $urandom_range(3, 1);
    end
    return 0;
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    int k;
    k = $urandom_range(99);
    if (k < 10) return SAMPLE_MIN;
    if (k < 15) return SAMPLE_MAX;
    if (k < 45) return 16'(int'($urandom_range(6)) - 3);
    return 16'($urandom);
  endfunction

  task automatic send_item(input wmp_op_e op, input logic [ADDR_BITS-1:0] addr,
                           input logic [SAMPLE_BITS_DEF-1:0] smp,
                           input logic [POS_BITS-1:0] col, input logic [POS_BITS-1:0] row,
                           input logic [PLANE_BITS-1:0] pl);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    sample_i    <= smp;
    out_col_i   <= col;
    out_row_i   <= row;
    plane_i     <= pl;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_STORE) n_store++;
    else n_pool++;
  endtask

  task automatic store_sample(input int addr, input logic [SAMPLE_BITS_DEF-1:0] smp);
    send_item(OP_STORE, addr[ADDR_BITS-1:0], smp, POS_BITS'($urandom),
              POS_BITS'($urandom), PLANE_BITS'($urandom));
    stored[addr[ADDR_BITS-1:0]] = 1'b1;
  endtask

  // write every entry the window will read that holds nothing yet
  task automatic fill_window(input int col, input int row, input int pl);
    int     win;
    int     r;
    int     c;
    longint h0;
    longint w0;
    longint ch;
    longint cw;
    longint flat;
    win = (cur_ws > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : cur_ws;
    if (col < cur_ow && row < cur_oh && pl < cur_pc) begin
      h0 = longint'(row) * cur_st - cur_pd;
      w0 = longint'(col) * cur_st - cur_pd;
      for (r = 0; r < win; r++) begin
        ch = h0 + r;
        if (ch >= 0 && ch < cur_ih) begin
          for (c = 0; c < win; c++) begin
            cw = w0 + c;
            if (cw >= 0 && cw < cur_iw) begin
              flat = cw + longint'(cur_iw) * (ch + longint'(cur_ih) * pl);
              if (flat < STORE_DEPTH_DEF) begin
                if (!stored[int'(flat)]) store_sample(int'(flat), pick_sample());
              end
            end
          end
        end
      end
    end
  endtask

  task automatic pool_at(input int col, input int row, input int pl);
    fill_window(int'(col[POS_BITS-1:0]), int'(row[POS_BITS-1:0]),
                int'(pl[PLANE_BITS-1:0]));
    send_item(OP_POOL, ADDR_BITS'($urandom), SAMPLE_BITS_DEF'($urandom),
              col[POS_BITS-1:0], row[POS_BITS-1:0], pl[PLANE_BITS-1:0]);
  endtask

  // drop valid, let every result come back, then let the unit go quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input wmp_cfg_idx_e idx, input int unsigned value, input int width);
    logic [CFG_DATA_BITS-1:0] mask;
    logic [CFG_DATA_BITS-1:0] word;
    mask = CFG_DATA_BITS'((32'd1 << width) - 1);
    word = CFG_DATA_BITS'(value) & mask;
    if (cfg_junk) word = word | (CFG_DATA_BITS'($urandom) & ~mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic setup(input int iw, input int ih, input int ow, input int oh,
                       input int pc, input int ws, input int st, input int pd);
    wait_idle();
    write_reg(CFG_IN_WIDTH, iw, DIM_BITS);
    write_reg(CFG_IN_HEIGHT, ih, DIM_BITS);
    write_reg(CFG_OUT_WIDTH, ow, DIM_BITS);
    write_reg(CFG_OUT_HEIGHT, oh, DIM_BITS);
    write_reg(CFG_PLANE_COUNT, pc, PLANE_CNT_BITS);
    write_reg(CFG_WINDOW_SIZE, ws, WIN_BITS);
    write_reg(CFG_STEP, st, STEP_BITS);
    write_reg(CFG_PADDING, pd, PAD_BITS);
    cfg_valid_i <= 1'b0;
    cur_iw = iw % (1 << DIM_BITS);
    cur_ih = ih % (1 << DIM_BITS);
    cur_ow = ow % (1 << DIM_BITS);
    cur_oh = oh % (1 << DIM_BITS);
    cur_pc = pc % (1 << PLANE_CNT_BITS);
    cur_ws = ws % (1 << WIN_BITS);
    cur_st = st % (1 << STEP_BITS);
    cur_pd = pd % (1 << PAD_BITS);
    n_cfg++;
  endtask

  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_idle_pct);
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("window_max_pool_with_argmax_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int     iw, ih, ow, oh, pc, ws, st, pd;
    int     mode;
    int     kind;
    int     phase;
    int     phase_start;
    longint region;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = OP_STORE;
    address_i     = '0;
    sample_i      = '0;
    out_col_i     = '0;
    out_row_i     = '0;
    plane_i       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 30;
    cfg_junk      = 1'b0;
    n_store       = 0;
    n_pool        = 0;
    n_cfg         = 0;
    cur_iw        = CFG_RESET.in_width;
    cur_ih        = CFG_RESET.in_height;
    cur_ow        = CFG_RESET.out_width;
    cur_oh        = CFG_RESET.out_height;
    cur_pc        = CFG_RESET.plane_count;
    cur_ws        = CFG_RESET.window_size;
    cur_st        = CFG_RESET.step;
    cur_pd        = CFG_RESET.padding;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    pool_at(0, 0, 0);
    pool_at(1, 0, 0);

    // ties, sentinel-only window, out-of-range requests
    setup(4, 4, 2, 2, 2, 2, 2, 0);
    store_sample(0, SAMPLE_MAX);
    store_sample(1, SAMPLE_MAX);
    store_sample(4, SAMPLE_MIN);
    store_sample(5, 16'hffff);
    pool_at(0, 0, 0);
    store_sample(0, SAMPLE_MIN);
    store_sample(1, SAMPLE_MIN);
    store_sample(4, SAMPLE_MIN);
    store_sample(5, SAMPLE_MIN);
    pool_at(0, 0, 0);
    pool_at(1, 1, 1);
    pool_at(2, 0, 0);
    pool_at(0, 2, 0);
    pool_at(0, 0, 2);
    pool_at(1023, 1023, 4095);

    // padding clips the window at the map edges
    setup(4, 4, 3, 3, 2, 2, 2, 1);
    pool_at(0, 0, 0);
    pool_at(2, 2, 1);

    // largest map: most positions fall beyond the store
    setup(1024, 1024, 1024, 1024, 4096, 8, 8, 7);
    store_sample(STORE_DEPTH_DEF - 1, SAMPLE_MAX);
    pool_at(128, 8, 0);
    pool_at(1023, 1023, 4095);

    // empty map, empty window, oversized window with zero step
    setup(0, 4, 2, 2, 1, 2, 2, 0);
    pool_at(0, 0, 0);
    setup(4, 4, 2, 2, 1, 0, 1, 0);
    pool_at(1, 1, 0);
    setup(4, 4, 2, 2, 1, 15, 0, 0);
    pool_at(1, 1, 0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = $urandom_range(9);
      cfg_junk = ($urandom_range(3) == 0);
      if (mode == 0) begin
        iw = $urandom_range(2047, 256);
        ih = $urandom_range(2047, 1);
        ow = $urandom_range(2047, 1);
        oh = $urandom_range(2047, 1);
        pc = $urandom_range(8191, 1);
        ws = $urandom_range(15);
        st = $urandom_range(15);
        pd = $urandom_range(7);
      end else begin
        iw = $urandom_range(12, 1);
        ih = $urandom_range(12, 1);
        ow = $urandom_range(8, 1);
        oh = $urandom_range(8, 1);
        pc = $urandom_range(4, 1);
        ws = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(4, 1);
        st = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8);
        pd = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(ws > 1 ? ws - 1 : 0);
        if (mode == 1) begin
          if ($urandom_range(1)) iw = 0;
          else ih = 0;
        end
      end
      setup(iw, ih, ow, oh, pc, ws, st, pd);
      send_idle_pct = 20 * $urandom_range(2);
      recv_idle_pct = 20 * $urandom_range(2);
      region = longint'(cur_iw) * cur_ih * cur_pc;
      if (region > STORE_DEPTH_DEF) region = STORE_DEPTH_DEF;
      phase_start = n_store + n_pool;
      while (n_store + n_pool - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          store_sample((region > 0) ? int'($urandom_range(int'(region) - 1)) : int'($urandom),
                       pick_sample());
        end else if (kind < 40) begin
          store_sample($urandom, pick_sample());
        end else if (kind < 90) begin
          pool_at((cur_ow > 0) ? $urandom_range(cur_ow - 1) : $urandom,
                  (cur_oh > 0) ? $urandom_range(cur_oh - 1) : $urandom,
                  (cur_pc > 0) ? $urandom_range(cur_pc - 1) : $urandom);
        end else begin
          pool_at($urandom, $urandom, $urandom);
        end
        if ($urandom_range(99) == 0) wait_idle();
      end
    end

    wait_idle();
    $display("ran %0d stores (window fills included) and %0d pool queries", n_store, n_pool);
    $display("over %0d register settings, extremes and empty windows among them", n_cfg);
    if (mismatches == 0 && pending == 0) begin
      $display("window_max_pool_with_argmax_unit_tb: done, clean");
    end else begin
      $display("window_max_pool_with_argmax_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
